// File: rtl/spectral_kurtosis_estimator_core_assert.svh
// Assertion macros shared by the estimator core.
`ifndef SPECTRAL_KURTOSIS_ESTIMATOR_CORE_ASSERT_SVH
`define SPECTRAL_KURTOSIS_ESTIMATOR_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SKCE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SKCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/skce_pkg.sv
package skce_pkg;

    localparam int MAX_CHANNELS = 8192;
    localparam int MAX_GROUP    = 256;
    localparam int CH_W         = 13;
    localparam int POWER_W      = 24;
    localparam int PSQ_W        = 40;
    localparam int S1_W         = 32;
    localparam int S2_W         = 48;
    localparam int N_W          = 24;
    localparam int K_W          = 24;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECTRA_PER_GROUP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCUMULATION_COUNT = 2'd2;

    typedef enum logic [2:0] {
        E_IDLE,
        E_MUL1,
        E_MUL2,
        E_SUB,
        E_MUL3,
        E_MUL4,
        E_DIV,
        E_DONE
    } t_est_state;

    typedef struct packed {
        logic signed [K_W-1:0] kurtosis;
        logic                  zero_power;
    } t_est_res;

endpackage

// File: rtl/skce_in_if.sv
interface skce_in_if;
    import skce_pkg::*;
    logic               valid;
    logic               ready;
    logic [POWER_W-1:0] power;
    logic [PSQ_W-1:0]   power_squared;
    modport source (output valid, power, power_squared, input ready);
    modport sink (input valid, power, power_squared, output ready);
endinterface

// File: rtl/skce_out_if.sv
interface skce_out_if;
    import skce_pkg::*;
    logic                  valid;
    logic                  ready;
    logic signed [K_W-1:0] kurtosis;
    logic [CH_W-1:0]       channel;
    logic                  zero_power;
    logic                  last_channel;
    modport source (output valid, kurtosis, channel, zero_power, last_channel, input ready);
    modport sink (input valid, kurtosis, channel, zero_power, last_channel, output ready);
endinterface

// File: rtl/spectral_kurtosis_estimator_core.sv
// An item whose spectrum does not close a group reads the channel's sums from the two sum memories
// and writes them back, and the next item is taken only after the write-back. An item of a group's
// last spectrum also runs the estimate on a shared 24 by 32 bit multiplier (four products) and a
// 25-step restoring divider; a zero power sum finishes at once. A finished result waits in the
// output register while the next item is taken. After reset a clearing pass zeroes all 8192 entries
// of the sum memories, and no transaction is accepted on the input until it ends; configuration
// writes are taken throughout.
`include "spectral_kurtosis_estimator_core_assert.svh"

module spectral_kurtosis_estimator_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [skce_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [skce_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    skce_in_if.sink                          i_in,
    skce_out_if.source                       o_out
);
    import skce_pkg::*;

    logic [13:0]      r_cfg_cc;
    logic [8:0]       r_cfg_gg;
    logic [N_W-1:0]   r_cfg_n;
    logic [CH_W-1:0]  r_ch_pos;
    logic [7:0]       r_sp_pos;
    logic [CH_W-1:0]  r_tag_ch;
    logic             r_tag_last;
    logic             r_last_sp;
    logic             r_out_valid;
    logic signed [K_W-1:0] r_out_k;
    logic [CH_W-1:0]  r_out_ch;
    logic             r_out_zero;
    logic             r_out_last;
    logic [13:0]      w_cc;
    logic [8:0]       w_gg;
    logic [N_W-1:0]   w_n;
    logic             w_last_ch;
    logic             w_last_sp;
    logic             w_accept;
    logic             w_clearing;
    logic             w_pending;
    logic [S1_W-1:0]  w_s1;
    logic [S2_W-1:0]  w_s2;
    logic             w_est_start;
    logic             w_est_idle;
    logic             w_est_valid;
    logic             w_est_ack;
    t_est_res         w_est_res;

    skce_acc u_acc (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (w_accept),
        .i_ch            (r_ch_pos),
        .i_power         (i_in.power),
        .i_power_squared (i_in.power_squared),
        .i_clear_sums    (w_last_sp),
        .o_clearing      (w_clearing),
        .o_pending       (w_pending),
        .o_s1            (w_s1),
        .o_s2            (w_s2)
    );

    skce_est u_est (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_est_start),
        .i_s1    (w_s1),
        .i_s2    (w_s2),
        .i_n     (r_cfg_n < N_W'(2) ? N_W'(2) : r_cfg_n),
        .i_ack   (w_est_ack),
        .o_idle  (w_est_idle),
        .o_valid (w_est_valid),
        .o_res   (w_est_res)
    );

    always_comb begin
        w_cc = (r_cfg_cc == '0) ? 14'd1 :
               (r_cfg_cc > 14'(MAX_CHANNELS)) ? 14'(MAX_CHANNELS) : r_cfg_cc;
        w_gg = (r_cfg_gg == '0) ? 9'd1 :
               (r_cfg_gg > 9'(MAX_GROUP)) ? 9'(MAX_GROUP) : r_cfg_gg;
        w_n  = (r_cfg_n < N_W'(2)) ? N_W'(2) : r_cfg_n;
        w_last_ch   = {1'b0, r_ch_pos} >= (w_cc - 14'd1);
        w_last_sp   = {1'b0, r_sp_pos} >= (w_gg - 9'd1);
        i_in.ready  = !w_clearing && !w_pending && w_est_idle;
        w_accept    = i_in.valid && i_in.ready;
        w_est_start = w_pending && r_last_sp;
        w_est_ack   = w_est_valid && (!r_out_valid || o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cc    <= 14'd1024;
            r_cfg_gg    <= 9'd128;
            r_cfg_n     <= N_W'(128);
            r_ch_pos    <= '0;
            r_sp_pos    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHANNEL_COUNT:      r_cfg_cc <= i_cfg_data[13:0];
                    CFG_SPECTRA_PER_GROUP:  r_cfg_gg <= i_cfg_data[8:0];
                    CFG_ACCUMULATION_COUNT: r_cfg_n  <= i_cfg_data[N_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_accept) begin
                if (w_last_ch) begin
                    r_ch_pos <= '0;
                    r_sp_pos <= w_last_sp ? 8'd0 : r_sp_pos + 8'd1;
                end else begin
                    r_ch_pos <= r_ch_pos + 1'b1;
                end
            end
            if (w_est_ack) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_tag_ch   <= r_ch_pos;
            r_tag_last <= w_last_ch;
            r_last_sp  <= w_last_sp;
        end
        if (w_est_ack) begin
            r_out_k    <= w_est_res.kurtosis;
            r_out_zero <= w_est_res.zero_power;
            r_out_ch   <= r_tag_ch;
            r_out_last <= r_tag_last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.kurtosis     = r_out_k;
    assign o_out.channel      = r_out_ch;
    assign o_out.zero_power   = r_out_zero;
    assign o_out.last_channel = r_out_last;

    `SKCE_ASSERT_NOW(a_no_accept_in_clear, w_clearing, !i_in.ready, "input ready while clearing")
    `SKCE_ASSERT_NEXT(a_interlock, w_accept, !i_in.ready, "ready during read-modify-write")
    `SKCE_ASSERT_NOW(a_est_free, w_est_start, w_est_idle, "estimate started while busy")
    `SKCE_ASSERT_NOW(a_n_min, 1'b1, w_n >= N_W'(2), "accumulation count below two")

endmodule

// File: rtl/skce_acc.sv
module skce_acc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [skce_pkg::CH_W-1:0]    i_ch,
    input  logic [skce_pkg::POWER_W-1:0] i_power,
    input  logic [skce_pkg::PSQ_W-1:0]   i_power_squared,
    input  logic                        i_clear_sums,
    output logic                        o_clearing,
    output logic                        o_pending,
    output logic [skce_pkg::S1_W-1:0]    o_s1,
    output logic [skce_pkg::S2_W-1:0]    o_s2
);
    import skce_pkg::*;

    logic [S1_W-1:0]    mem_s1 [0:MAX_CHANNELS-1];
    logic [S2_W-1:0]    mem_s2 [0:MAX_CHANNELS-1];
    logic [S1_W-1:0]    r_rd_s1;
    logic [S2_W-1:0]    r_rd_s2;
    logic               r_clearing;
    logic [CH_W-1:0]    r_clr_idx;
    logic               r_rd;
    logic [CH_W-1:0]    r_ch;
    logic [POWER_W-1:0] r_p;
    logic [PSQ_W-1:0]   r_p2;
    logic               r_clr_sums;
    logic [S1_W:0]      w_sum1;
    logic [S2_W:0]      w_sum2;
    logic               w_we;
    logic [CH_W-1:0]    w_waddr;
    logic [S1_W-1:0]    w_wd1;
    logic [S2_W-1:0]    w_wd2;

    always_comb begin
        w_sum1 = {1'b0, r_rd_s1} + {(S1_W + 1 - POWER_W)'(0), r_p};
        w_sum2 = {1'b0, r_rd_s2} + {(S2_W + 1 - PSQ_W)'(0), r_p2};
        o_s1   = w_sum1[S1_W] ? '1 : w_sum1[S1_W-1:0];
        o_s2   = w_sum2[S2_W] ? '1 : w_sum2[S2_W-1:0];
        w_we    = r_clearing || r_rd;
        w_waddr = r_clearing ? r_clr_idx : r_ch;
        w_wd1   = (r_clearing || r_clr_sums) ? '0 : o_s1;
        w_wd2   = (r_clearing || r_clr_sums) ? '0 : o_s2;
    end

    assign o_clearing = r_clearing;
    assign o_pending  = r_rd;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_s1[w_waddr] <= w_wd1;
        end
        r_rd_s1 <= mem_s1[i_ch];
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_s2[w_waddr] <= w_wd2;
        end
        r_rd_s2 <= mem_s2[i_ch];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
            r_rd       <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_idx <= r_clr_idx + 1'b1;
                if (r_clr_idx == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            r_rd <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_ch       <= i_ch;
            r_p        <= i_power;
            r_p2       <= i_power_squared;
            r_clr_sums <= i_clear_sums;
        end
    end

endmodule

// File: rtl/skce_mul.sv
module skce_mul (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [71:0]  i_x,
    input  logic [31:0]  i_y,
    output logic         o_done,
    output logic [103:0] o_p
);
    logic [71:0]  r_x;
    logic [31:0]  r_y;
    logic [1:0]   r_k;
    logic         r_busy;
    logic [55:0]  r_pp;
    logic [1:0]   r_ppk;
    logic         r_ppv;
    logic         r_done;
    logic [103:0] r_acc;
    logic [23:0]  w_limb;
    logic [103:0] w_shifted;

    always_comb begin
        case (r_k)
            2'd0:    w_limb = r_x[23:0];
            2'd1:    w_limb = r_x[47:24];
            default: w_limb = r_x[71:48];
        endcase
        case (r_ppk)
            2'd0:    w_shifted = {48'd0, r_pp};
            2'd1:    w_shifted = {24'd0, r_pp, 24'd0};
            default: w_shifted = {r_pp, 48'd0};
        endcase
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_ppv  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_ppv && (r_ppk == 2'd2);
            r_ppv  <= r_busy;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_k == 2'd2) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_k   <= 2'd0;
            r_acc <= '0;
        end else begin
            if (r_busy) begin
                r_k <= r_k + 2'd1;
            end
            if (r_ppv) begin
                r_acc <= r_acc + w_shifted;
            end
        end
        r_pp  <= 56'(w_limb) * 56'(r_y);
        r_ppk <= r_k;
    end

endmodule

// File: rtl/skce_est.sv
module skce_est (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [skce_pkg::S1_W-1:0] i_s1,
    input  logic [skce_pkg::S2_W-1:0] i_s2,
    input  logic [skce_pkg::N_W-1:0]  i_n,
    input  logic                      i_ack,
    output logic                      o_idle,
    output logic                      o_valid,
    output skce_pkg::t_est_res        o_res
);
    import skce_pkg::*;

    t_est_state     r_state;
    t_est_state     n_state;
    logic [S2_W-1:0] r_s2;
    logic [N_W-1:0]  r_n;
    logic [63:0]     r_b;
    logic [71:0]     r_a;
    logic            r_neg;
    logic            r_zero;
    logic [114:0]    r_rem;
    logic [114:0]    r_dsh;
    logic [24:0]     r_q;
    logic [4:0]      r_bit;
    logic            w_mstart;
    logic [71:0]     w_mx;
    logic [31:0]     w_my;
    logic            w_mdone;
    logic [103:0]    w_mp;
    logic            w_ge;
    logic [71:0]     w_diff;
    logic            w_rge;

    skce_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mstart),
        .i_x     (w_mx),
        .i_y     (w_my),
        .o_done  (w_mdone),
        .o_p     (w_mp)
    );

    always_comb begin
        w_ge   = r_a >= {8'd0, r_b};
        w_diff = w_ge ? (r_a - {8'd0, r_b}) : ({8'd0, r_b} - r_a);
        w_rge  = r_rem >= r_dsh;
        n_state  = r_state;
        w_mstart = 1'b0;
        w_mx     = '0;
        w_my     = '0;
        case (r_state)
            E_IDLE: begin
                if (i_start) begin
                    if (i_s1 == '0) begin
                        n_state = E_DONE;
                    end else begin
                        w_mstart = 1'b1;
                        w_mx     = {40'd0, i_s1};
                        w_my     = i_s1;
                        n_state  = E_MUL1;
                    end
                end
            end
            E_MUL1: begin
                if (w_mdone) begin
                    w_mstart = 1'b1;
                    w_mx     = {24'd0, r_s2};
                    w_my     = {8'd0, r_n};
                    n_state  = E_MUL2;
                end
            end
            E_MUL2: begin
                if (w_mdone) begin
                    n_state = E_SUB;
                end
            end
            E_SUB: begin
                w_mstart = 1'b1;
                w_mx     = w_diff;
                w_my     = {8'd0, r_n} + 32'd1;
                n_state  = E_MUL3;
            end
            E_MUL3: begin
                if (w_mdone) begin
                    w_mstart = 1'b1;
                    w_mx     = {8'd0, r_b};
                    w_my     = {8'd0, r_n} - 32'd1;
                    n_state  = E_MUL4;
                end
            end
            E_MUL4: begin
                if (w_mdone) begin
                    n_state = E_DIV;
                end
            end
            E_DIV: begin
                if (r_bit == '0) begin
                    n_state = E_DONE;
                end
            end
            E_DONE: begin
                if (i_ack) begin
                    n_state = E_IDLE;
                end
            end
            default: n_state = E_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            E_IDLE: begin
                r_s2   <= i_s2;
                r_n    <= i_n;
                r_zero <= (i_s1 == '0);
                r_neg  <= 1'b0;
                r_q    <= '0;
            end
            E_MUL1: begin
                if (w_mdone) begin
                    r_b <= w_mp[63:0];
                end
            end
            E_MUL2: begin
                if (w_mdone) begin
                    r_a <= w_mp[71:0];
                end
            end
            E_SUB: begin
                r_neg <= !w_ge;
            end
            E_MUL3: begin
                if (w_mdone) begin
                    r_rem <= {1'b0, w_mp[96:0], 17'd0};
                end
            end
            E_MUL4: begin
                if (w_mdone) begin
                    r_rem <= r_rem + {27'd0, w_mp[87:0]};
                    r_dsh <= {2'd0, w_mp[87:0], 25'd0};
                    r_bit <= 5'd24;
                end
            end
            E_DIV: begin
                if (w_rge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_q   <= {r_q[23:0], w_rge};
                r_dsh <= {1'b0, r_dsh[114:1]};
                r_bit <= r_bit - 5'd1;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_res.zero_power = r_zero;
        if (r_zero) begin
            o_res.kurtosis = '0;
        end else if (r_neg) begin
            o_res.kurtosis = (r_q > 25'd8388608) ? 24'sh800000 : K_W'(25'd0 - r_q);
        end else begin
            o_res.kurtosis = (r_q > 25'd8388607) ? 24'sh7FFFFF : r_q[K_W-1:0];
        end
    end

    assign o_idle  = (r_state == E_IDLE);
    assign o_valid = (r_state == E_DONE);

endmodule
